### rtl/core/nhtl_pkg.sv
// nhtl_pkg: widths, register indexes and sequencer states of the tree locality block
// used by the channel interfaces, nearest_host_by_tree_locality, nhtl_checker and tb; no dependencies
package nhtl_pkg;

    // field widths
    localparam int HOST_W = 12;
    localparam int CNT_W  = 13;
    localparam int FAN_W  = 7;
    localparam int LVL_W  = 4;

    // largest host count the tree can hold
    localparam int MAX_HOSTS = 4096;

    // reciprocal multiply: a quotient of a HOST_W-bit value by any 7-bit divisor is exact
    // with a shift of HOST_W + FAN_W and a rounded-up reciprocal
    localparam int RCP_SHIFT = HOST_W + FAN_W;
    localparam int RCP_W     = RCP_SHIFT;
    localparam int PROD_W    = HOST_W + RCP_W;
    localparam int FAN_DEPTH = 1 << FAN_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FANOUT     = 1'b1;

    // reset values and the fanout floor
    localparam logic [CNT_W-1:0] HOST_COUNT_RST = CNT_W'(4096);
    localparam logic [FAN_W-1:0] FANOUT_RST     = FAN_W'(16);
    localparam logic [FAN_W-1:0] FANOUT_MIN     = FAN_W'(2);
    localparam logic [LVL_W-1:0] LVL_NONE       = LVL_W'(15);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_MB,
        S_MC,
        S_DONE
    } t_state;

endpackage

### rtl/core/nhtl_item_if.sv
// nhtl_item_if: candidate word channel with valid/ready handshake
// depends on nhtl_pkg for field widths
interface nhtl_item_if;
    logic                       valid;
    logic                       ready;
    logic [nhtl_pkg::HOST_W-1:0] target_host;
    logic [nhtl_pkg::HOST_W-1:0] candidate_host;
    logic                       candidate_valid;
    logic                       last_candidate;

    modport source (
        output valid, target_host, candidate_host, candidate_valid, last_candidate,
        input  ready
    );
    modport sink (
        input  valid, target_host, candidate_host, candidate_valid, last_candidate,
        output ready
    );
endinterface

### rtl/core/nhtl_result_if.sv
// nhtl_result_if: result word channel with valid/ready handshake
// depends on nhtl_pkg for field widths
interface nhtl_result_if;
    logic                        valid;
    logic                        ready;
    logic [nhtl_pkg::HOST_W-1:0] nearest_host;
    logic                        found;
    logic [nhtl_pkg::LVL_W-1:0]  shared_level;
    logic                        target_error;

    modport source (
        output valid, nearest_host, found, shared_level, target_error,
        input  ready
    );
    modport sink (
        input  valid, nearest_host, found, shared_level, target_error,
        output ready
    );
endinterface

### rtl/core/nearest_host_by_tree_locality.sv
// nearest_host_by_tree_locality: picks the candidate host closest to a target in a fanout tree
// depends on nhtl_pkg, nhtl_item_if and nhtl_result_if
//
//  channel    dir  word                                                    when taken
//  i_item     in   target_host, candidate_host, candidate_valid, last      valid & ready
//  o_result   out  nearest_host, found, shared_level, target_error         valid & ready
//  i_cfg_*    in   register index, write data                              i_cfg_wr_en high
//
// a word is taken only in the idle state; one multiplier with a reciprocal table walks the
// tree one level per pass through S_MB and S_MC, dividing target then candidate by the fanout
// skipped or out-of-range word: S_DONE only; evaluated word: S_CHK, then S_MB and S_MC per
// level for L levels walked (L up to 12, cut short once no better level is possible)
// a last word waits in the final state while the result register is still full
// i_rst_n is synchronous: config returns to 4096 hosts, fanout 16, and the list clears
module nearest_host_by_tree_locality (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [nhtl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nhtl_pkg::CNT_W-1:0]         i_cfg_wdata,
    nhtl_item_if.sink                          i_item,
    nhtl_result_if.source                      o_result
);
    import nhtl_pkg::*;

    // reciprocal table, one rounded-up entry per fanout code
    logic [RCP_W-1:0] w_recip [FAN_DEPTH];
    for (genvar g = 0; g < FAN_DEPTH; g++) begin : g_recip
        localparam int FD = (g < 2) ? 2 : g;
        localparam logic [RCP_W-1:0] RC = RCP_W'(((1 << RCP_SHIFT) + FD - 1) / FD);
        assign w_recip[g] = RC;
    end

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_host_count;
    logic [FAN_W-1:0]  r_fanout;

    logic [HOST_W-1:0] r_a, n_a;
    logic [HOST_W-1:0] r_b, n_b;
    logic [HOST_W-1:0] r_cand, n_cand;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [RCP_W-1:0]  r_recip, n_recip;
    logic              r_last, n_last;
    logic              r_terr, n_terr;

    logic [HOST_W-1:0] r_best_host, n_best_host;
    logic [LVL_W-1:0]  r_best_lvl, n_best_lvl;
    logic              r_have_best, n_have_best;

    logic              r_out_valid, n_out_valid;
    logic [HOST_W-1:0] r_out_host, n_out_host;
    logic              r_out_found, n_out_found;
    logic [LVL_W-1:0]  r_out_lvl, n_out_lvl;
    logic              r_out_terr, n_out_terr;

    logic [CNT_W-1:0]  w_hosts;
    logic [FAN_W-1:0]  w_fan;
    logic              w_in_terr;
    logic              w_eval;
    logic              w_take;
    logic              w_mul_b;
    logic [HOST_W-1:0] w_mul_op;
    logic [PROD_W-1:0] w_prod;
    logic [HOST_W-1:0] w_quot;
    logic [LVL_W-1:0]  w_lvl_inc;
    logic [LVL_W-1:0]  w_lvl_inc2;
    logic              w_same_chk;
    logic              w_same_mc;
    logic              w_stop_chk;
    logic              w_stop_mc;
    logic              w_out_free;

    // effective configuration
    assign w_hosts = (r_host_count > CNT_W'(MAX_HOSTS)) ? CNT_W'(MAX_HOSTS) : r_host_count;
    assign w_fan   = (r_fanout < FANOUT_MIN) ? FANOUT_MIN : r_fanout;

    // input word checks
    assign w_in_terr = {1'b0, i_item.target_host} >= w_hosts;
    assign w_eval    = i_item.candidate_valid && !w_in_terr
                       && ({1'b0, i_item.candidate_host} < w_hosts);
    assign w_take    = i_item.valid && i_item.ready;

    // shared multiplier: target in most cycles, candidate in S_MB
    assign w_mul_op = w_mul_b ? r_b : r_a;
    assign w_prod   = PROD_W'(w_mul_op) * PROD_W'(r_recip);
    assign w_quot   = r_prod[RCP_SHIFT +: HOST_W];

    // level tracking and early stop
    assign w_lvl_inc  = r_lvl + LVL_W'(1);
    assign w_lvl_inc2 = r_lvl + LVL_W'(2);
    assign w_same_chk = (r_a == r_b);
    assign w_same_mc  = (r_a == w_quot);
    assign w_stop_chk = w_same_chk || (w_lvl_inc >= r_best_lvl);
    assign w_stop_mc  = w_same_mc || (w_lvl_inc2 >= r_best_lvl);

    assign w_out_free = !r_out_valid || o_result.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_state = w_eval ? S_CHK : S_DONE;
                end
            end
            S_CHK: begin
                n_state = w_stop_chk ? S_DONE : S_MB;
            end
            S_MB: begin
                n_state = S_MC;
            end
            S_MC: begin
                n_state = w_stop_mc ? S_DONE : S_MB;
            end
            S_DONE: begin
                if (!r_last || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_item.ready = 1'b0;
        w_mul_b      = 1'b0;
        case (r_state)
            S_IDLE:  i_item.ready = 1'b1;
            S_MB:    w_mul_b      = 1'b1;
            default: begin
                i_item.ready = 1'b0;
                w_mul_b      = 1'b0;
            end
        endcase
    end

    // datapath and best-so-far update
    always_comb begin
        n_a         = r_a;
        n_b         = r_b;
        n_cand      = r_cand;
        n_lvl       = r_lvl;
        n_prod      = r_prod;
        n_recip     = r_recip;
        n_last      = r_last;
        n_terr      = r_terr;
        n_best_host = r_best_host;
        n_best_lvl  = r_best_lvl;
        n_have_best = r_have_best;
        n_out_host  = r_out_host;
        n_out_found = r_out_found;
        n_out_lvl   = r_out_lvl;
        n_out_terr  = r_out_terr;
        n_out_valid = o_result.ready ? 1'b0 : r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_a     = i_item.target_host;
                    n_b     = i_item.candidate_host;
                    n_cand  = i_item.candidate_host;
                    n_lvl   = '0;
                    n_last  = i_item.last_candidate;
                    n_terr  = w_in_terr;
                    n_recip = w_recip[w_fan];
                end
            end
            S_CHK: begin
                if (w_same_chk) begin
                    if (r_lvl < r_best_lvl) begin
                        n_best_host = r_cand;
                        n_best_lvl  = r_lvl;
                        n_have_best = 1'b1;
                    end
                end else begin
                    n_prod = w_prod;
                end
            end
            S_MB: begin
                // target quotient lands, candidate goes through the multiplier
                n_a    = w_quot;
                n_prod = w_prod;
            end
            S_MC: begin
                n_b   = w_quot;
                n_lvl = w_lvl_inc;
                if (w_same_mc) begin
                    if (w_lvl_inc < r_best_lvl) begin
                        n_best_host = r_cand;
                        n_best_lvl  = w_lvl_inc;
                        n_have_best = 1'b1;
                    end
                end else begin
                    n_prod = w_prod;
                end
            end
            S_DONE: begin
                if (r_last && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_host  = r_have_best ? r_best_host : '0;
                    n_out_found = r_have_best;
                    n_out_lvl   = r_have_best ? r_best_lvl : '0;
                    n_out_terr  = r_terr;
                    n_best_host = '0;
                    n_best_lvl  = LVL_NONE;
                    n_have_best = 1'b0;
                end
            end
            default: begin
                n_a = r_a;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_best_host  <= '0;
            r_best_lvl   <= LVL_NONE;
            r_have_best  <= 1'b0;
            r_host_count <= HOST_COUNT_RST;
            r_fanout     <= FANOUT_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_best_host <= n_best_host;
            r_best_lvl  <= n_best_lvl;
            r_have_best <= n_have_best;
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_HOST_COUNT: r_host_count <= i_cfg_wdata;
                    CFG_FANOUT:     r_fanout     <= i_cfg_wdata[FAN_W-1:0];
                    default:        r_fanout     <= r_fanout;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_cand      <= n_cand;
        r_lvl       <= n_lvl;
        r_prod      <= n_prod;
        r_recip     <= n_recip;
        r_last      <= n_last;
        r_terr      <= n_terr;
        r_out_host  <= n_out_host;
        r_out_found <= n_out_found;
        r_out_lvl   <= n_out_lvl;
        r_out_terr  <= n_out_terr;
    end

    // result channel
    assign o_result.valid        = r_out_valid;
    assign o_result.nearest_host = r_out_host;
    assign o_result.found        = r_out_found;
    assign o_result.shared_level = r_out_lvl;
    assign o_result.target_error = r_out_terr;

endmodule

### dv/nhtl_checker.sv
// nhtl_checker: watches the config port and both word channels of the tree locality block,
// predicts each result word and compares it field by field
// depends on nhtl_pkg, nhtl_item_if and nhtl_result_if
module nhtl_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [nhtl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nhtl_pkg::CNT_W-1:0]     i_cfg_wdata,
    nhtl_item_if                           i_item,
    nhtl_result_if                         i_result,
    output int                             o_fail_count,
    output int                             o_pending
);
    import nhtl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [HOST_W-1:0] nearest;
        logic              found;
        logic [LVL_W-1:0]  level;
        logic              target_err;
    } t_nearest_word;

    // predictor copy of the registers and the per-list selection
    logic [CNT_W-1:0]  host_count_q;
    logic [FAN_W-1:0]  fanout_q;
    logic [HOST_W-1:0] pick_host;
    logic [LVL_W-1:0]  pick_level;
    logic              pick_valid;

    t_nearest_word expected_words[$];
    int            fail_total = 0;
    int            pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // lowest tree level whose node holds both hosts
    function automatic logic [LVL_W-1:0] meet_level(input logic [HOST_W-1:0] a,
                                                     input logic [HOST_W-1:0] b,
                                                     input int unsigned fan);
        int unsigned x;
        int unsigned y;
        int unsigned lvl;
        x   = a;
        y   = b;
        lvl = 0;
        while (x != y) begin
            x = x / fan;
            y = y / fan;
            lvl++;
        end
        return lvl[LVL_W-1:0];
    endfunction

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        int unsigned   hosts;
        int unsigned   fan;
        logic          terr;
        logic [LVL_W-1:0] lvl;
        t_nearest_word want;
        t_nearest_word got;
        if (!i_rst_n) begin
            host_count_q = HOST_COUNT_RST;
            fanout_q     = FANOUT_RST;
            pick_host    = '0;
            pick_level   = LVL_NONE;
            pick_valid   = 1'b0;
            expected_words.delete();
        end else begin
            // register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_HOST_COUNT: host_count_q = i_cfg_wdata;
                    CFG_FANOUT:     fanout_q     = i_cfg_wdata[FAN_W-1:0];
                    default: ;
                endcase
            end

            // compare an accepted result word with the oldest prediction
            if (i_result.valid && i_result.ready) begin
                got = '{i_result.nearest_host, i_result.found, i_result.shared_level,
                        i_result.target_error};
                if (expected_words.size() == 0) begin
                    report("result word with nothing pending (nearest_host)", 0, got.nearest);
                end else begin
                    want = expected_words.pop_front();
                    if (got.nearest !== want.nearest)
                        report("nearest_host", want.nearest, got.nearest);
                    if (got.found !== want.found)
                        report("found", want.found, got.found);
                    if (got.level !== want.level)
                        report("shared_level", want.level, got.level);
                    if (got.target_err !== want.target_err)
                        report("target_error", want.target_err, got.target_err);
                end
            end

            // fold an accepted candidate word into the selection
            if (i_item.valid && i_item.ready) begin
                hosts = (host_count_q > MAX_HOSTS) ? MAX_HOSTS : host_count_q;
                fan   = (fanout_q < FANOUT_MIN) ? FANOUT_MIN : fanout_q;
                terr  = (i_item.target_host >= hosts);
                if (i_item.candidate_valid && !terr && i_item.candidate_host < hosts) begin
                    lvl = meet_level(i_item.target_host, i_item.candidate_host, fan);
                    if (lvl < pick_level) begin
                        pick_level = lvl;
                        pick_host  = i_item.candidate_host;
                        pick_valid = 1'b1;
                    end
                end
                if (i_item.last_candidate) begin
                    want.nearest    = pick_valid ? pick_host : '0;
                    want.found      = pick_valid;
                    want.level      = pick_valid ? pick_level : '0;
                    want.target_err = terr;
                    expected_words.push_back(want);
                    pick_host  = '0;
                    pick_level = LVL_NONE;
                    pick_valid = 1'b0;
                end
            end
        end
        pending_total = expected_words.size();
    end

endmodule

### dv/tb.sv
// tb: stimulus and verdict for nearest_host_by_tree_locality
// depends on nhtl_pkg, nhtl_item_if, nhtl_result_if and nhtl_checker
module tb;
    import nhtl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 40;
    localparam int NUM_PHASES   = 15;
    localparam int PHASE_WORDS  = 102;
    localparam int HOLD_CYCLES  = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CNT_W-1:0]     cfg_wdata;
    int                   fail_count;
    int                   pending;

    nhtl_item_if   item_ch ();
    nhtl_result_if result_ch ();

    nearest_host_by_tree_locality dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    nhtl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // state for the stimulus, the result receiver and the run length guard
    bit steady = 1'b0;
    int ready_hold_req = 0;
    int words_sent = 0;
    int cycle_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run length guard
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // result receiver: random stalls, a forced long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold_req != 0) begin
                hold_left      = ready_hold_req;
                ready_hold_req = 0;
            end else if (!steady && hold_left == 0 && $urandom_range(0, 99) < 3) begin
                hold_left = $urandom_range(8, 40);
            end
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    // offer one candidate word and wait until the block takes it
    task automatic send_word(input logic [HOST_W-1:0] tgt, input logic [HOST_W-1:0] cand,
                             input logic cvalid, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.target_host     <= tgt;
        item_ch.candidate_host  <= cand;
        item_ch.candidate_valid <= cvalid;
        item_ch.last_candidate  <= last;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // stop offering and let every pending result word come out
    task automatic wait_quiet();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CNT_W-1:0] hosts, input logic [CNT_W-1:0] fan);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= CFG_HOST_COUNT;
        cfg_wdata <= hosts;
        @(posedge i_clk);
        cfg_idx   <= CFG_FANOUT;
        cfg_wdata <= fan;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // one candidate list, mostly well formed, with many candidates near the target
    task automatic run_list(input int unsigned hosts, input int unsigned fan);
        int               len;
        int               r;
        int               span;
        logic [HOST_W-1:0] tgt;
        logic [HOST_W-1:0] cand;
        logic [HOST_W-1:0] tgt_now;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
        r   = $urandom_range(0, 99);
        tgt = (r < 85 && hosts > 0) ? HOST_W'($urandom_range(0, hosts - 1))
                                    : HOST_W'($urandom_range(0, 4095));
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                case ($urandom_range(0, 2))
                    0:       span = 1;
                    1:       span = fan;
                    default: span = fan * fan;
                endcase
                cand = HOST_W'(int'(tgt) + $urandom_range(0, 2 * span) - span);
            end else if (r < 80 && hosts > 0) begin
                cand = HOST_W'($urandom_range(0, hosts - 1));
            end else begin
                cand = HOST_W'($urandom_range(0, 4095));
            end
            tgt_now = ($urandom_range(0, 29) == 0) ? HOST_W'($urandom_range(0, 4095)) : tgt;
            send_word(tgt_now, cand, ($urandom_range(0, 15) != 0), (i == len - 1));
        end
    endtask

    // stimulus
    initial begin
        logic [CNT_W-1:0] hc_tab [NUM_PHASES];
        logic [CNT_W-1:0] fo_tab [NUM_PHASES];
        int unsigned      hosts_eff;
        int unsigned      fan_eff;
        int               goal;

        hc_tab[0] = 13'd4096; fo_tab[0] = 13'd2;
        hc_tab[1] = 13'd4096; fo_tab[1] = 13'd64;
        hc_tab[2] = 13'd1;    fo_tab[2] = 13'd2;
        hc_tab[3] = 13'd100;  fo_tab[3] = 13'd3;
        hc_tab[4] = 13'd0;    fo_tab[4] = 13'd16;
        hc_tab[5] = 13'd8191; fo_tab[5] = 13'd0;
        hc_tab[6] = 13'd5000; fo_tab[6] = 13'd1;
        hc_tab[7] = 13'd1000; fo_tab[7] = 13'd127;
        hc_tab[8] = 13'd4096; fo_tab[8] = 13'd16;
        for (int p = 9; p < NUM_PHASES; p++) begin
            hc_tab[p] = CNT_W'($urandom_range(1, 4096));
            fo_tab[p] = CNT_W'($urandom_range(2, 64));
        end

        i_rst_n                 <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_idx                 <= CFG_HOST_COUNT;
        cfg_wdata               <= '0;
        item_ch.valid           <= 1'b0;
        item_ch.target_host     <= '0;
        item_ch.candidate_host  <= '0;
        item_ch.candidate_valid <= 1'b0;
        item_ch.last_candidate  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, 4096 hosts with fanout 16
        send_word(12'd0,    12'd0,    1'b1, 1'b1);
        send_word(12'd4095, 12'd4095, 1'b1, 1'b1);
        send_word(12'd0,    12'd4095, 1'b1, 1'b1);
        send_word(12'd4095, 12'd0,    1'b1, 1'b1);
        // strictly lower level wins, first one kept on a tie
        send_word(12'd17,   12'd300,  1'b1, 1'b0);
        send_word(12'd17,   12'd20,   1'b1, 1'b0);
        send_word(12'd17,   12'd31,   1'b1, 1'b0);
        send_word(12'd17,   12'd17,   1'b1, 1'b1);
        // empty list, then an empty word inside a list
        send_word(12'd0,    12'd0,    1'b0, 1'b1);
        send_word(12'd42,   12'd42,   1'b0, 1'b0);
        send_word(12'd42,   12'd43,   1'b1, 1'b1);
        send_word(12'd2730, 12'd1365, 1'b1, 1'b1);
        wait_quiet();

        // directed: 100 hosts, invalid targets and out-of-range candidates
        write_cfg(13'd100, 13'd16);
        send_word(12'd150,  12'd5,    1'b1, 1'b1);
        send_word(12'd5,    12'd7,    1'b1, 1'b0);
        send_word(12'd200,  12'd5,    1'b1, 1'b1);
        send_word(12'd5,    12'd120,  1'b1, 1'b1);
        send_word(12'd99,   12'd99,   1'b1, 1'b1);
        send_word(12'd99,   12'd100,  1'b1, 1'b1);
        send_word(12'd100,  12'd99,   1'b1, 1'b1);
        wait_quiet();

        // directed: no hosts at all, fanout below two
        write_cfg(13'd0, 13'd1);
        send_word(12'd0,    12'd0,    1'b1, 1'b1);
        wait_quiet();

        // directed: saturated host count, fanout zero walks all twelve levels
        write_cfg(13'd8191, 13'd0);
        send_word(12'd4095, 12'd0,    1'b1, 1'b1);
        send_word(12'd4094, 12'd4095, 1'b1, 1'b1);
        wait_quiet();

        // random phases over a range of tree shapes
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_cfg(hc_tab[p], fo_tab[p]);
            hosts_eff = (hc_tab[p] > MAX_HOSTS) ? MAX_HOSTS : hc_tab[p];
            fan_eff   = (fo_tab[p] < FANOUT_MIN) ? FANOUT_MIN : fo_tab[p];
            steady    = (p % 4 == 3);
            if (p == 1)
                ready_hold_req = HOLD_CYCLES;
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal)
                run_list(hosts_eff, fan_eff);
            wait_quiet();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
rtl/core/nhtl_pkg.sv
rtl/core/nhtl_item_if.sv
rtl/core/nhtl_result_if.sv
rtl/core/nearest_host_by_tree_locality.sv
dv/nhtl_checker.sv
dv/tb.sv
